// ----- hw/rtl/backslash_escape_decoder_macros.svh -----
// Assertion macros used by the escape decoder back end.
// Needs clk, and for BED_ASSERT also rst_n, in the scope where a macro is used.
`ifndef BACKSLASH_ESCAPE_DECODER_MACROS_SVH
`define BACKSLASH_ESCAPE_DECODER_MACROS_SVH

// Checked only out of reset.
`define BED_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define BED_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/bed_pkg.sv -----
// Shared types, character codes and decode helpers of the escape decoder.
// No dependencies.
`default_nettype none
package bed_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  // characters
  localparam logic [7:0] BSL_CHAR = 8'h5C;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_LC    = 8'h63;
  localparam logic [7:0] CH_LE    = 8'h65;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LN    = 8'h6E;
  localparam logic [7:0] CH_LR    = 8'h72;
  localparam logic [7:0] CH_LT    = 8'h74;
  localparam logic [7:0] CH_LV    = 8'h76;
  localparam logic [7:0] CH_LX    = 8'h78;

  // control codes produced by letter escapes
  localparam logic [7:0] BEL_CODE = 8'h07;
  localparam logic [7:0] BS_CODE  = 8'h08;
  localparam logic [7:0] HT_CODE  = 8'h09;
  localparam logic [7:0] LF_CODE  = 8'h0A;
  localparam logic [7:0] VT_CODE  = 8'h0B;
  localparam logic [7:0] FF_CODE  = 8'h0C;
  localparam logic [7:0] CR_CODE  = 8'h0D;
  localparam logic [7:0] ESC_CODE = 8'h1B;

  localparam logic [1:0] MAX_RES = 2'd3;

  // Results of one request: n items (1..3) in data[0..n-1].
  typedef struct packed {
    logic [1:0]      n;
    logic            empty;  // lone end marker, no byte
    logic            eos;    // last item closes the string
    logic [2:0][7:0] data;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } qbus_t;

  function automatic res_t res_push(res_t r, logic [7:0] b);
    res_t o;
    o = r;
    if (r.n != MAX_RES) begin
      o.data[r.n] = b;
      o.n = r.n + 2'd1;
    end
    return o;
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [4:0] v;
    v = '0;
    if (c >= CH_0 && c <= CH_9) v = {1'b1, 4'(c - CH_0)};
    else if (c >= CH_LA && c <= CH_LF) v = {1'b1, 4'(c - CH_LA + 8'd10)};
    else if (c >= CH_UA && c <= CH_UF) v = {1'b1, 4'(c - CH_UA + 8'd10)};
    return v;
  endfunction

  function automatic logic is_octal(logic [7:0] c);
    return (c >= CH_0) && (c <= CH_7);
  endfunction

  // {valid, byte}
  function automatic logic [8:0] letter_escape(logic [7:0] c);
    logic [8:0] v;
    case (c)
      BSL_CHAR: v = {1'b1, BSL_CHAR};
      CH_LA:    v = {1'b1, BEL_CODE};
      CH_LB:    v = {1'b1, BS_CODE};
      CH_LE:    v = {1'b1, ESC_CODE};
      CH_LF:    v = {1'b1, FF_CODE};
      CH_LN:    v = {1'b1, LF_CODE};
      CH_LR:    v = {1'b1, CR_CODE};
      CH_LT:    v = {1'b1, HT_CODE};
      CH_LV:    v = {1'b1, VT_CODE};
      default:  v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/bed_front.sv -----
// Front end: escape state machine, decodes one request into a result bundle.
// Depends on bed_pkg.
`default_nettype none
module bed_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_wr_en,
  input  wire logic          cfg_wr_data,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_byte,
  input  wire logic          in_last,
  input  wire logic          q_full,
  output bed_pkg::qbus_t     q_wr
);

  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_BSL   = 3'd1;
  localparam logic [2:0] MODE_ZERO  = 3'd2;
  localparam logic [2:0] MODE_OCT   = 3'd3;
  localparam logic [2:0] MODE_XSEEN = 3'd4;
  localparam logic [2:0] MODE_HEX   = 3'd5;
  localparam logic [2:0] MODE_STOP  = 3'd6;

  logic [2:0] mode_r, mode_nxt;
  logic [8:0] val_r, val_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       en_r;
  bed_pkg::res_t res;
  logic       take;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  always_comb begin
    logic [4:0] hv;
    logic [8:0] lv;
    logic       plain_b;
    hv      = bed_pkg::hex_val(in_byte);
    lv      = bed_pkg::letter_escape(in_byte);
    mode_nxt = mode_r;
    val_nxt  = val_r;
    cnt_nxt  = cnt_r;
    res      = '0;
    plain_b  = 1'b0;
    case (mode_r)
      MODE_IDLE: plain_b = 1'b1;
      MODE_BSL: begin
        mode_nxt = MODE_IDLE;
        if (lv[8]) res = bed_pkg::res_push(res, lv[7:0]);
        else if (in_byte == bed_pkg::CH_LC) mode_nxt = MODE_STOP;
        else if (in_byte == bed_pkg::CH_0) mode_nxt = MODE_ZERO;
        else if (in_byte == bed_pkg::CH_LX) mode_nxt = MODE_XSEEN;
        else begin
          res = bed_pkg::res_push(res, bed_pkg::BSL_CHAR);
          res = bed_pkg::res_push(res, in_byte);
        end
      end
      MODE_ZERO: begin
        if (bed_pkg::is_octal(in_byte)) begin
          mode_nxt = MODE_OCT;
          val_nxt  = {6'd0, in_byte[2:0]};
          cnt_nxt  = 2'd1;
        end else begin
          mode_nxt = MODE_IDLE;
          res = bed_pkg::res_push(res, bed_pkg::BSL_CHAR);
          res = bed_pkg::res_push(res, bed_pkg::CH_0);
          plain_b = 1'b1;
        end
      end
      MODE_OCT: begin
        if (bed_pkg::is_octal(in_byte)) begin
          if (cnt_r == 2'd2) begin
            res = bed_pkg::res_push(res, {val_r[4:0], in_byte[2:0]});
            mode_nxt = MODE_IDLE;
            val_nxt  = '0;
            cnt_nxt  = '0;
          end else begin
            val_nxt = {val_r[5:0], in_byte[2:0]};
            cnt_nxt = cnt_r + 2'd1;
          end
        end else begin
          res = bed_pkg::res_push(res, val_r[7:0]);
          mode_nxt = MODE_IDLE;
          val_nxt  = '0;
          cnt_nxt  = '0;
          plain_b  = 1'b1;
        end
      end
      MODE_XSEEN: begin
        if (hv[4]) begin
          mode_nxt = MODE_HEX;
          val_nxt  = {5'd0, hv[3:0]};
          cnt_nxt  = 2'd1;
        end else begin
          mode_nxt = MODE_IDLE;
          res = bed_pkg::res_push(res, bed_pkg::BSL_CHAR);
          res = bed_pkg::res_push(res, bed_pkg::CH_LX);
          plain_b = 1'b1;
        end
      end
      MODE_HEX: begin
        if (hv[4]) res = bed_pkg::res_push(res, {val_r[3:0], hv[3:0]});
        else begin
          res = bed_pkg::res_push(res, val_r[7:0]);
          plain_b = 1'b1;
        end
        mode_nxt = MODE_IDLE;
        val_nxt  = '0;
        cnt_nxt  = '0;
      end
      default: ;  // stopped by \c: drop
    endcase

    // byte handled as ordinary text, may open a new escape
    if (plain_b) begin
      if (in_byte == bed_pkg::BSL_CHAR && en_r) mode_nxt = MODE_BSL;
      else res = bed_pkg::res_push(res, in_byte);
    end

    if (in_last) begin
      case (mode_nxt)
        MODE_BSL: res = bed_pkg::res_push(res, bed_pkg::BSL_CHAR);
        MODE_ZERO: begin
          res = bed_pkg::res_push(res, bed_pkg::BSL_CHAR);
          res = bed_pkg::res_push(res, bed_pkg::CH_0);
        end
        MODE_XSEEN: begin
          res = bed_pkg::res_push(res, bed_pkg::BSL_CHAR);
          res = bed_pkg::res_push(res, bed_pkg::CH_LX);
        end
        MODE_OCT, MODE_HEX: res = bed_pkg::res_push(res, val_nxt[7:0]);
        default: ;
      endcase
      if (res.n == 2'd0) begin
        res.n     = 2'd1;
        res.empty = 1'b1;
      end
      res.eos  = 1'b1;
      mode_nxt = MODE_IDLE;
      val_nxt  = '0;
      cnt_nxt  = '0;
    end
  end

  assign q_wr.valid = take && (res.n != 2'd0);
  assign q_wr.res   = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      val_r  <= '0;
      cnt_r  <= '0;
      en_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) en_r <= cfg_wr_data;
      if (take) begin
        mode_r <= mode_nxt;
        val_r  <= val_nxt;
        cnt_r  <= cnt_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/bed_queue.sv -----
// Short bundle queue between decoder front and output serialiser.
// Depends on bed_pkg.
`default_nettype none
module bed_queue #(
  parameter int DEPTH = bed_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire bed_pkg::qbus_t wr,
  output logic                full,
  output bed_pkg::qbus_t      rd,
  input  wire logic           pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bed_pkg::res_t   mem_r [DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [CW-1:0]   cnt_r;
  logic            do_push, do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign do_push  = wr.valid && !full;
  assign do_pop   = pop && (cnt_r != '0);
  assign rd.valid = (cnt_r != '0);
  assign rd.res   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wr.res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (do_pop)  rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/bed_back.sv -----
// Back end: walks the head bundle onto the output port, one result per cycle while out_ready is high.
// Depends on bed_pkg and the assertion macro header.
`default_nettype none
`include "backslash_escape_decoder_macros.svh"
module bed_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire bed_pkg::qbus_t rd,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          out_byte,
  output logic                out_has_byte,
  output logic                out_string_end
);

  logic [1:0] idx_r, idx_nxt;
  logic       last_item;
  logic       fire;

  assign last_item      = (idx_r == rd.res.n - 2'd1);
  assign fire           = out_valid && out_ready;
  assign pop            = fire && last_item;
  assign out_valid      = rd.valid;
  assign out_byte       = rd.res.data[idx_r];
  assign out_has_byte   = !rd.res.empty;
  assign out_string_end = rd.res.eos && last_item;

  always_comb begin
    idx_nxt = idx_r;
    if (fire) idx_nxt = last_item ? 2'd0 : idx_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) idx_r <= '0;
    else        idx_r <= idx_nxt;
  end

  `BED_ASSERT(a_idx_in_bundle, rd.valid |-> (idx_r < rd.res.n), "item index past bundle end")
  `BED_ASSERT(a_marker_alone, (rd.valid && rd.res.empty) |-> (rd.res.eos && rd.res.n == 2'd1), "end marker not alone")
  `BED_ASSERT_ALWAYS(a_idx_idle, !rd.valid |-> (idx_r == 2'd0), "index held with empty queue")

endmodule
`default_nettype wire

// ----- hw/rtl/backslash_escape_decoder.sv -----
// Accepted bundles are registered in the queue; its head feeds the output port.
// Throughput: one request per cycle while each gives one result and out_ready
// stays high. A request with more results holds the output longer; with the
// two-entry queue the input then stalls even when out_ready stays high.
// Reset (rst_n low, synchronous): escape decoding off, decoder idle, queue empty.
// Requests that give no result (an opening backslash) never occupy the queue.
`default_nettype none
module backslash_escape_decoder #(
  parameter int QUEUE_DEPTH = bed_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // configuration: escape enable
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data,
  // input request channel
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  // result channel
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_has_byte,
  output logic            out_string_end
);

  // Front: escape state machine turns each request into a bundle of one to
  // three results (or none) combinationally.
  // Queue: bundles wait here, so input acceptance depends only on queue room,
  // never directly on out_ready.
  // Back: hands the head bundle out one item per cycle while out_ready is high.

  bed_pkg::qbus_t q_wr, q_rd;
  logic           q_full;
  logic           q_pop;

  bed_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .in_last     (in_last),
    .q_full      (q_full),
    .q_wr        (q_wr)
  );

  bed_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .full  (q_full),
    .rd    (q_rd),
    .pop   (q_pop)
  );

  bed_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .rd             (q_rd),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_has_byte   (out_has_byte),
    .out_string_end (out_string_end)
  );

endmodule
`default_nettype wire

// ----- sim/backslash_escape_decoder_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for backslash_escape_decoder: directed escape table, then random strings.
// Depends on bed_pkg and the decoder RTL only; its model predicts results of untyped requests.
module backslash_escape_decoder_test;

  // decoder model states
  typedef enum logic [2:0] {
    ST_IDLE, ST_ESC, ST_ZERO, ST_OCT, ST_XSEEN, ST_HEX, ST_STOP
  } dec_mode_t;

  // one output character as the block presents it
  typedef struct packed {
    logic [7:0] ch;
    logic       has;
    logic       eos;
  } out_char_t;

  // one directed request; typed rows carry their expected characters
  typedef struct packed {
    logic [7:0]      ch;
    logic            last;
    logic            en;
    logic            typed;
    logic [1:0]      n;
    logic [0:2][7:0] exp_chars;
  } step_row_t;

  localparam int N_ROWS = 28;
  localparam step_row_t DIRECTED [N_ROWS] = '{
    // escapes off after reset: everything passes straight through
    '{8'h00,             1'b0, 1'b0, 1'b1, 2'd1, {8'h00, 16'h0}},
    '{8'hFF,             1'b1, 1'b0, 1'b1, 2'd1, {8'hFF, 16'h0}},
    '{bed_pkg::BSL_CHAR, 1'b1, 1'b0, 1'b1, 2'd1, {bed_pkg::BSL_CHAR, 16'h0}},
    // unknown escape letter 'q' keeps its backslash
    '{bed_pkg::BSL_CHAR, 1'b0, 1'b1, 1'b1, 2'd0, 24'h0},
    '{8'h71,             1'b0, 1'b1, 1'b1, 2'd2, {bed_pkg::BSL_CHAR, 8'h71, 8'h00}},
    // \0777 overflows a byte, low byte kept
    '{bed_pkg::BSL_CHAR, 1'b0, 1'b1, 1'b1, 2'd0, 24'h0},
    '{bed_pkg::CH_0,     1'b0, 1'b1, 1'b1, 2'd0, 24'h0},
    '{bed_pkg::CH_7,     1'b0, 1'b1, 1'b1, 2'd0, 24'h0},
    '{bed_pkg::CH_7,     1'b0, 1'b1, 1'b1, 2'd0, 24'h0},
    '{bed_pkg::CH_7,     1'b0, 1'b1, 1'b1, 2'd1, {8'hFF, 16'h0}},
    // \x with no digit: three literal characters, string closed on the last
    '{bed_pkg::BSL_CHAR, 1'b0, 1'b1, 1'b1, 2'd0, 24'h0},
    '{bed_pkg::CH_LX,    1'b0, 1'b1, 1'b1, 2'd0, 24'h0},
    '{8'h67,             1'b1, 1'b1, 1'b1, 2'd3, {bed_pkg::BSL_CHAR, bed_pkg::CH_LX, 8'h67}},
    // octal cut short by '9' at end of string
    '{bed_pkg::BSL_CHAR, 1'b0, 1'b1, 1'b0, 2'd0, 24'h0},
    '{bed_pkg::CH_0,     1'b0, 1'b1, 1'b0, 2'd0, 24'h0},
    '{8'h31,             1'b0, 1'b1, 1'b0, 2'd0, 24'h0},
    '{bed_pkg::CH_9,     1'b1, 1'b1, 1'b0, 2'd0, 24'h0},
    // one hex digit pending at end of string is flushed
    '{bed_pkg::BSL_CHAR, 1'b0, 1'b1, 1'b0, 2'd0, 24'h0},
    '{bed_pkg::CH_LX,    1'b0, 1'b1, 1'b0, 2'd0, 24'h0},
    '{bed_pkg::CH_UA,    1'b1, 1'b1, 1'b0, 2'd0, 24'h0},
    // \c swallows the rest, last byte gives an empty end marker
    '{bed_pkg::BSL_CHAR, 1'b0, 1'b1, 1'b1, 2'd0, 24'h0},
    '{bed_pkg::CH_LC,    1'b0, 1'b1, 1'b1, 2'd0, 24'h0},
    '{8'h7A,             1'b0, 1'b1, 1'b1, 2'd0, 24'h0},
    '{8'h7A,             1'b1, 1'b1, 1'b1, 2'd0, 24'h0},
    // trailing lone backslash
    '{bed_pkg::BSL_CHAR, 1'b1, 1'b1, 1'b1, 2'd1, {bed_pkg::BSL_CHAR, 16'h0}},
    // escapes switched off mid-escape: the open escape still completes
    '{bed_pkg::BSL_CHAR, 1'b0, 1'b1, 1'b1, 2'd0, 24'h0},
    '{bed_pkg::CH_LN,    1'b0, 1'b0, 1'b1, 2'd1, {bed_pkg::LF_CODE, 16'h0}},
    '{bed_pkg::BSL_CHAR, 1'b1, 1'b0, 1'b1, 2'd1, {bed_pkg::BSL_CHAR, 16'h0}}
  };

  localparam logic [7:0] LETTERS [9] = '{
    bed_pkg::BSL_CHAR, bed_pkg::CH_LA, bed_pkg::CH_LB, bed_pkg::CH_LE, bed_pkg::CH_LF,
    bed_pkg::CH_LN, bed_pkg::CH_LR, bed_pkg::CH_LT, bed_pkg::CH_LV
  };
  // enable per random phase, bit p for phase p
  localparam logic [7:0] ENABLE_PLAN = 8'b1011_0101;
  localparam int N_PHASES = 8;
  localparam int PHASE_REQS = 45;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_has_byte;
  logic       out_string_end;

  // model state, kept in step with the block
  dec_mode_t  dmode = ST_IDLE;
  logic [8:0] dval = '0;
  logic [1:0] dcnt = '0;
  logic       esc_on = 1'b0;

  out_char_t  step_chars[$];    // characters caused by the current request
  out_char_t  chars_due[$];     // characters still to come from the block
  logic [7:0] str_q[$];         // random string being sent
  logic       str_open;         // leave the string unterminated
  logic       no_gaps = 1'b0;   // back-to-back stretch on both sides

  int n_reqs = 0;
  int n_checked = 0;
  int n_wrong = 0;
  int n_writes = 0;

  always #5 clk = ~clk;

  backslash_escape_decoder u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_has_byte   (out_has_byte),
    .out_string_end (out_string_end)
  );

  // ---------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------

  // at most three characters per request; extras are dropped as in the block
  function automatic void put_char(logic [7:0] c);
    out_char_t r;
    if (step_chars.size() < 3) begin
      r.ch  = c;
      r.has = 1'b1;
      r.eos = 1'b0;
      step_chars.push_back(r);
    end
  endfunction

  function automatic void back_to_idle();
    dmode = ST_IDLE;
    dval  = '0;
    dcnt  = '0;
  endfunction

  // a byte seen outside an escape; a backslash only opens one when enabled
  function automatic void take_plain(logic [7:0] c);
    if (c == bed_pkg::BSL_CHAR && esc_on) dmode = ST_ESC;
    else put_char(c);
  endfunction

  function automatic int hex_digit(logic [7:0] c);
    if (c >= bed_pkg::CH_0 && c <= bed_pkg::CH_9) return int'(c - bed_pkg::CH_0);
    if (c >= bed_pkg::CH_LA && c <= bed_pkg::CH_LF) return int'(c - bed_pkg::CH_LA) + 10;
    if (c >= bed_pkg::CH_UA && c <= bed_pkg::CH_UF) return int'(c - bed_pkg::CH_UA) + 10;
    return -1;
  endfunction

  function automatic int letter_code(logic [7:0] c);
    case (c)
      bed_pkg::BSL_CHAR: return int'(bed_pkg::BSL_CHAR);
      bed_pkg::CH_LA:    return int'(bed_pkg::BEL_CODE);
      bed_pkg::CH_LB:    return int'(bed_pkg::BS_CODE);
      bed_pkg::CH_LE:    return int'(bed_pkg::ESC_CODE);
      bed_pkg::CH_LF:    return int'(bed_pkg::FF_CODE);
      bed_pkg::CH_LN:    return int'(bed_pkg::LF_CODE);
      bed_pkg::CH_LR:    return int'(bed_pkg::CR_CODE);
      bed_pkg::CH_LT:    return int'(bed_pkg::HT_CODE);
      bed_pkg::CH_LV:    return int'(bed_pkg::VT_CODE);
      default:           return -1;
    endcase
  endfunction

  // Advance the model by one request; its characters are left in step_chars.
  function automatic void decode_byte(logic [7:0] c, logic last);
    int v;
    out_char_t r;
    step_chars.delete();
    case (dmode)
      ST_IDLE: take_plain(c);
      ST_ESC: begin
        dmode = ST_IDLE;
        v = letter_code(c);
        if (v >= 0) put_char(8'(v));
        else if (c == bed_pkg::CH_LC) dmode = ST_STOP;
        else if (c == bed_pkg::CH_0) dmode = ST_ZERO;
        else if (c == bed_pkg::CH_LX) dmode = ST_XSEEN;
        else begin
          put_char(bed_pkg::BSL_CHAR);
          put_char(c);
        end
      end
      ST_ZERO: begin
        if (c >= bed_pkg::CH_0 && c <= bed_pkg::CH_7) begin
          dmode = ST_OCT;
          dval  = {6'd0, c[2:0]};
          dcnt  = 2'd1;
        end else begin
          dmode = ST_IDLE;
          put_char(bed_pkg::BSL_CHAR);
          put_char(bed_pkg::CH_0);
          take_plain(c);
        end
      end
      ST_OCT: begin
        if (c >= bed_pkg::CH_0 && c <= bed_pkg::CH_7) begin
          dval = {dval[5:0], c[2:0]};   // times eight, kept to nine bits
          dcnt = dcnt + 2'd1;
          if (dcnt == 2'd3) begin
            put_char(dval[7:0]);
            back_to_idle();
          end
        end else begin
          // digit run cut short: value out, then the byte on its own
          put_char(dval[7:0]);
          back_to_idle();
          take_plain(c);
        end
      end
      ST_XSEEN: begin
        v = hex_digit(c);
        if (v >= 0) begin
          dmode = ST_HEX;
          dval  = 9'(v);
          dcnt  = 2'd1;
        end else begin
          dmode = ST_IDLE;
          put_char(bed_pkg::BSL_CHAR);
          put_char(bed_pkg::CH_LX);
          take_plain(c);
        end
      end
      ST_HEX: begin
        v = hex_digit(c);
        if (v >= 0) begin
          put_char({dval[3:0], 4'(v)});
          back_to_idle();
        end else begin
          put_char(dval[7:0]);
          back_to_idle();
          take_plain(c);
        end
      end
      default: ;   // stopped by \c: drop
    endcase
    if (last) begin
      // flush whatever escape is still open
      case (dmode)
        ST_ESC: put_char(bed_pkg::BSL_CHAR);
        ST_ZERO: begin
          put_char(bed_pkg::BSL_CHAR);
          put_char(bed_pkg::CH_0);
        end
        ST_XSEEN: begin
          put_char(bed_pkg::BSL_CHAR);
          put_char(bed_pkg::CH_LX);
        end
        ST_OCT, ST_HEX: put_char(dval[7:0]);
        default: ;
      endcase
      if (step_chars.size() == 0) begin
        r = '0;   // empty end marker
        step_chars.push_back(r);
      end
      r = step_chars.pop_back();
      r.eos = 1'b1;
      step_chars.push_back(r);
      back_to_idle();
    end
  endfunction

  // ---------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------

  // Offer one request after a random gap, wait for it to be taken, then
  // run the model. With own_exp set the caller queues the expectation.
  task automatic send_char(input logic [7:0] c, input logic last, input logic own_exp);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= c;
    in_last  <= last;
    do @(posedge clk); while (!in_ready);
    n_reqs++;
    decode_byte(c, last);
    if (!own_exp)
      while (step_chars.size() > 0) chars_due.push_back(step_chars.pop_front());
  endtask

  // stop sending and let every outstanding character come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (chars_due.size() > 0) @(posedge clk);
  endtask

  // Enable is only written with the block quiet: the write follows the drain and a pause.
  task automatic set_enable(input logic en);
    drain();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= en;
    esc_on = en;
    n_writes++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly well-formed escapes with random content, some noise strings.
  task automatic build_string();
    int kind;
    int k;
    str_q.delete();
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 6)) str_q.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 5)) begin
        kind = $urandom_range(0, 19);
        if (kind < 6) begin
          str_q.push_back(8'($urandom));
        end else begin
          str_q.push_back(bed_pkg::BSL_CHAR);
          if (kind < 9) begin
            str_q.push_back(LETTERS[$urandom_range(0, 8)]);
          end else if (kind < 12) begin
            str_q.push_back(bed_pkg::CH_0);
            repeat ($urandom_range(0, 3))
              str_q.push_back(8'(bed_pkg::CH_0 + $urandom_range(0, 7)));
          end else if (kind < 15) begin
            str_q.push_back(bed_pkg::CH_LX);
            repeat ($urandom_range(0, 2)) begin
              k = $urandom_range(0, 21);
              if (k < 10) str_q.push_back(8'(bed_pkg::CH_0 + k));
              else if (k < 16) str_q.push_back(8'(bed_pkg::CH_LA + k - 10));
              else str_q.push_back(8'(bed_pkg::CH_UA + k - 16));
            end
          end else if (kind == 15) begin
            str_q.push_back(bed_pkg::CH_LC);
          end else if (kind < 19) begin
            str_q.push_back(8'($urandom));
          end
          // kind 19: lone backslash, whatever follows decides its fate
        end
      end
    end
    // now and then run on into the next string
    str_open = ($urandom_range(0, 9) == 0);
  endtask

  // ---------------------------------------------------------------------
  // Result side: random stalls, check against the oldest expectation
  // ---------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    out_char_t want;
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 6);
      repeat (stall) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_valid));
      if (chars_due.size() == 0) begin
        $error("unexpected result: out_byte %02h out_has_byte %0b out_string_end %0b",
               out_byte, out_has_byte, out_string_end);
        n_wrong++;
      end else begin
        want = chars_due.pop_front();
        n_checked++;
        if (out_byte !== want.ch) begin
          $error("out_byte: expected %02h, actual %02h", want.ch, out_byte);
          n_wrong++;
        end
        if (out_has_byte !== want.has) begin
          $error("out_has_byte: expected %0b, actual %0b", want.has, out_has_byte);
          n_wrong++;
        end
        if (out_string_end !== want.eos) begin
          $error("out_string_end: expected %0b, actual %0b", want.eos, out_string_end);
          n_wrong++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin : stimulus
    int target;
    out_char_t r;
    logic held;
    held = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table; enable follows each row, written only when it changes
    for (int i = 0; i < N_ROWS; i++) begin
      if (DIRECTED[i].en != esc_on) set_enable(DIRECTED[i].en);
      send_char(DIRECTED[i].ch, DIRECTED[i].last, DIRECTED[i].typed);
      if (DIRECTED[i].typed) begin
        if (DIRECTED[i].n == 2'd0 && DIRECTED[i].last) begin
          r = '0;
          r.eos = 1'b1;
          chars_due.push_back(r);
        end
        for (int k = 0; k < int'(DIRECTED[i].n); k++) begin
          r.ch  = DIRECTED[i].exp_chars[k];
          r.has = 1'b1;
          r.eos = DIRECTED[i].last && (k == int'(DIRECTED[i].n) - 1);
          chars_due.push_back(r);
        end
      end
    end

    // random phases, each under its own enable; two run without gaps
    for (int p = 0; p < N_PHASES; p++) begin
      set_enable(ENABLE_PLAN[p]);
      no_gaps = (p == 2 || p == 5);
      target = n_reqs + PHASE_REQS;
      while (n_reqs < target) begin
        build_string();
        foreach (str_q[i])
          send_char(str_q[i], (i == str_q.size() - 1) && !str_open, 1'b0);
        // hold the sender once until the output side has caught up
        if (p == 3 && !held && n_reqs >= target - PHASE_REQS / 2) begin
          drain();
          held = 1'b1;
        end
      end
    end
    no_gaps = 1'b0;

    drain();
    repeat (10) @(posedge clk);
    $display("Sent %0d requests (directed escapes, then random strings), %0d results checked.",
             n_reqs, n_checked);
    $display("Escape enable written %0d times; gaps and stalls of 0 to 6 cycles on both sides.",
             n_writes);
    if (n_wrong == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("Timed out with %0d results outstanding.", chars_due.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/bed_pkg.sv
hw/rtl/bed_front.sv
hw/rtl/bed_queue.sv
hw/rtl/bed_back.sv
hw/rtl/backslash_escape_decoder.sv
sim/backslash_escape_decoder_test.sv
